// File: src/vfp_pkg.sv
// Shared types and constants of the vblank frame pacer.
`default_nettype none

package vfp_pkg;

    localparam int TIME_W   = 63;
    localparam int WIDE_W   = 64;
    localparam int PERIOD_W = 40;
    localparam int CFG_W    = 32;
    localparam int HIT_W    = 8;
    localparam int REFR_W   = 20;
    localparam int IDX_W    = 3;
    localparam int DIV_W    = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Picoseconds-per-millihertz numerator: period_ns = 10^12 / refresh_mhz.
    localparam logic [DIV_W-1:0] PS_PER_MHZ = 64'd1000000000000;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_PRESENT = 1'b1;

    localparam logic [1:0] ACT_RENDER  = 2'd0;
    localparam logic [1:0] ACT_ARMED   = 2'd1;
    localparam logic [1:0] ACT_PRESENT = 2'd2;

    localparam logic [IDX_W-1:0] REG_MIN_DELAY   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MARGIN_STEP = 3'd1;
    localparam logic [IDX_W-1:0] REG_HITS        = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_MARGIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_INIT_MARGIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_REFRESH     = 3'd5;

    localparam logic [CFG_W-1:0]  RST_MIN_DELAY   = 32'd1000000;
    localparam logic [CFG_W-1:0]  RST_MARGIN_STEP = 32'd250000;
    localparam logic [HIT_W-1:0]  RST_HITS        = 8'd60;
    localparam logic [CFG_W-1:0]  RST_MIN_MARGIN  = 32'd1000000;
    localparam logic [CFG_W-1:0]  RST_INIT_MARGIN = 32'd2000000;
    localparam logic [REFR_W-1:0] RST_REFRESH     = 20'd60000;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_ns;
        logic [CFG_W-1:0]  event_period_ns;
        logic              may_wait;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] start_ns;
        logic [CFG_W-1:0]  margin_ns;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quotient;
        logic [PERIOD_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_DIFF,
        S_REQ_ABS,
        S_REQ_DIV,
        S_REQ_NEXT1,
        S_REQ_NEXT2,
        S_REQ_START,
        S_REQ_LEAD,
        S_REQ_DECIDE,
        S_PRS_PER,
        S_PRS_DIV,
        S_PRS_CHK,
        S_PRS_CMP,
        S_PRS_WIDEN,
        S_PRS_HIT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: src/vfp_chan.sv
// Valid/ready channel carrying one payload item per request.
`default_nettype none

interface vfp_chan #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/vblank_frame_pacer_top.sv
// Top level of the vblank frame pacer: sequencer, pacing state and output register.
// Usage:
//   i_in carries one request at a time: a frame request (mode 0) with the
//   current time and may_wait, or a presented event (mode 1) with the vblank
//   time and the reported period. o_out returns exactly one result per
//   request: the action, the timer start time when armed, and the margin.
//   i_cfg writes six tuning indices; the initial margin index writes the
//   live margin directly. Writes are taken only while idle,
//   ahead of a request offered in the same cycle.
// Timing:
//   A frame request that predicts a vblank, and a present that derives its
//   period from the refresh rate, wait on the bit-serial divider; a present
//   checked against an aimed vblank passes through further states. Other
//   requests skip the divider. A new request is accepted in the cycle after
//   the previous result loads, at the earliest.
// Reset and stall:
//   Reset restores the register defaults, clears the vblank, period, aim
//   and hit count, and loads the default margin. A finished result sits in
//   the output register until taken; the next request may be accepted
//   meanwhile, but its own result waits until the register frees.
`default_nettype none

module vblank_frame_pacer_top (
    input wire     i_clk,
    input wire     i_rst_n,
    vfp_chan.sink   i_in,
    vfp_chan.source o_out,
    vfp_chan.sink   i_cfg
);

    localparam int TW = vfp_pkg::TIME_W;
    localparam int XW = vfp_pkg::WIDE_W;
    localparam int PW = vfp_pkg::PERIOD_W;
    localparam int CW = vfp_pkg::CFG_W;

    vfp_pkg::t_state    r_state;
    vfp_pkg::t_state    n_state;
    vfp_pkg::t_div_req  w_div_req;
    vfp_pkg::t_div_rsp  w_div_rsp;
    vfp_pkg::t_in_item  w_in;
    vfp_pkg::t_cfg_wr   w_cfg;

    logic [CW-1:0]               r_min_delay;
    logic [CW-1:0]               r_step;
    logic [vfp_pkg::HIT_W-1:0]   r_hits;
    logic [CW-1:0]               r_min_margin;
    logic [vfp_pkg::REFR_W-1:0]  r_refresh;

    logic [TW-1:0]               r_last;
    logic [PW-1:0]               r_period;
    logic [XW-1:0]               r_aimed;
    logic [CW-1:0]               r_margin;
    logic [vfp_pkg::HIT_W-1:0]   r_hit;

    logic [TW-1:0]               r_now;
    logic [CW-1:0]               r_ev;
    logic                        r_neg;
    logic [XW-1:0]               r_tmp;
    logic [XW-1:0]               r_next;
    logic [XW-1:0]               r_start;
    logic [CW+2:0]               r_wide;
    logic [1:0]                  r_action;
    logic [TW-1:0]               r_start_out;

    logic                        r_out_valid;
    vfp_pkg::t_out_item          r_out;

    logic w_in_ready;
    logic w_cfg_ready;
    logic w_in_acc;
    logic w_cfg_acc;
    logic w_out_load;
    logic w_req_ok;
    logic w_late;
    logic w_lead_ok;

    logic [XW-1:0]               w_rem_s;
    logic [PW-1:0]               w_cap;
    logic [PW-1:0]               w_min_wc;
    logic [vfp_pkg::HIT_W-1:0]   w_hit_n;
    logic [CW-1:0]               w_cand;

    assign w_in  = i_in.payload;
    assign w_cfg = i_cfg.payload;

    assign w_in_acc  = i_in.valid & w_in_ready;
    assign w_cfg_acc = i_cfg.valid & w_cfg_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = w_cfg_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    vfp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Datapath decisions, on registered values except w_req_ok, which also uses the incoming may_wait.
    always_comb begin
        w_req_ok  = w_in.may_wait && (r_last != '0) && (r_period != '0);
        w_late    = {1'b0, r_now} > r_tmp;
        w_lead_ok = !r_tmp[XW-1] && (r_tmp > {{(XW-CW){1'b0}}, r_min_delay});
        // Truncating division leaves the remainder with the dividend's sign.
        w_rem_s   = r_neg ? (XW'(0) - {{(XW-PW){1'b0}}, w_div_rsp.remainder})
                          : {{(XW-PW){1'b0}}, w_div_rsp.remainder};
        w_cap     = {1'b0, r_period[PW-1:1]};
        w_min_wc  = ({{(PW-CW-3){1'b0}}, r_wide} < w_cap)
                    ? {{(PW-CW-3){1'b0}}, r_wide} : w_cap;
        w_hit_n   = r_hit + vfp_pkg::HIT_W'(1);
        w_cand    = (r_margin > r_step) ? (r_margin - r_step) : '0;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_in.mode == vfp_pkg::MODE_PRESENT) begin
                        n_state = vfp_pkg::S_PRS_PER;
                    end else if (w_req_ok) begin
                        n_state = vfp_pkg::S_REQ_DIFF;
                    end else begin
                        n_state = vfp_pkg::S_FINISH;
                    end
                end
            end
            vfp_pkg::S_REQ_DIFF:   n_state = vfp_pkg::S_REQ_ABS;
            vfp_pkg::S_REQ_ABS:    n_state = vfp_pkg::S_REQ_DIV;
            vfp_pkg::S_REQ_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = vfp_pkg::S_REQ_NEXT1;
                end
            end
            vfp_pkg::S_REQ_NEXT1:  n_state = vfp_pkg::S_REQ_NEXT2;
            vfp_pkg::S_REQ_NEXT2:  n_state = vfp_pkg::S_REQ_START;
            vfp_pkg::S_REQ_START:  n_state = vfp_pkg::S_REQ_LEAD;
            vfp_pkg::S_REQ_LEAD:   n_state = vfp_pkg::S_REQ_DECIDE;
            vfp_pkg::S_REQ_DECIDE: n_state = vfp_pkg::S_FINISH;
            vfp_pkg::S_PRS_PER: begin
                if (r_ev == '0 && r_refresh != '0) begin
                    n_state = vfp_pkg::S_PRS_DIV;
                end else begin
                    n_state = vfp_pkg::S_PRS_CHK;
                end
            end
            vfp_pkg::S_PRS_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = vfp_pkg::S_PRS_CHK;
                end
            end
            vfp_pkg::S_PRS_CHK: begin
                if (r_aimed == '0 || r_period == '0) begin
                    n_state = vfp_pkg::S_FINISH;
                end else begin
                    n_state = vfp_pkg::S_PRS_CMP;
                end
            end
            vfp_pkg::S_PRS_CMP: begin
                n_state = w_late ? vfp_pkg::S_PRS_WIDEN : vfp_pkg::S_PRS_HIT;
            end
            vfp_pkg::S_PRS_WIDEN:  n_state = vfp_pkg::S_FINISH;
            vfp_pkg::S_PRS_HIT:    n_state = vfp_pkg::S_FINISH;
            vfp_pkg::S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = vfp_pkg::S_IDLE;
                end
            end
            default: n_state = vfp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_in_ready         = 1'b0;
        w_cfg_ready        = 1'b0;
        w_out_load         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_tmp[XW-1] ? (XW'(0) - r_tmp) : r_tmp;
        w_div_req.divisor  = r_period;
        unique case (r_state)
            vfp_pkg::S_IDLE: begin
                // A pending register write goes ahead of a new request.
                w_cfg_ready = 1'b1;
                w_in_ready  = !i_cfg.valid;
            end
            vfp_pkg::S_REQ_ABS: w_div_req.start = 1'b1;
            vfp_pkg::S_PRS_PER: begin
                w_div_req.start    = (r_ev == '0) && (r_refresh != '0);
                w_div_req.dividend = vfp_pkg::PS_PER_MHZ;
                w_div_req.divisor  = {{(PW-vfp_pkg::REFR_W){1'b0}}, r_refresh};
            end
            vfp_pkg::S_FINISH:  w_out_load = !r_out_valid || o_out.ready;
            default: begin
            end
        endcase
    end

    // Control and pacing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vfp_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_min_delay  <= vfp_pkg::RST_MIN_DELAY;
            r_step       <= vfp_pkg::RST_MARGIN_STEP;
            r_hits       <= vfp_pkg::RST_HITS;
            r_min_margin <= vfp_pkg::RST_MIN_MARGIN;
            r_refresh    <= vfp_pkg::RST_REFRESH;
            r_last       <= '0;
            r_period     <= '0;
            r_aimed      <= '0;
            r_margin     <= vfp_pkg::RST_INIT_MARGIN;
            r_hit        <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_acc) begin
                unique case (w_cfg.index)
                    vfp_pkg::REG_MIN_DELAY:   r_min_delay  <= w_cfg.data;
                    vfp_pkg::REG_MARGIN_STEP: r_step       <= w_cfg.data;
                    vfp_pkg::REG_HITS:        r_hits       <= w_cfg.data[vfp_pkg::HIT_W-1:0];
                    vfp_pkg::REG_MIN_MARGIN:  r_min_margin <= w_cfg.data;
                    vfp_pkg::REG_INIT_MARGIN: r_margin     <= w_cfg.data;
                    vfp_pkg::REG_REFRESH:     r_refresh    <= w_cfg.data[vfp_pkg::REFR_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                vfp_pkg::S_IDLE: begin
                    if (w_in_acc && w_in.mode == vfp_pkg::MODE_REQUEST && !w_req_ok) begin
                        r_aimed <= '0;
                    end
                end
                vfp_pkg::S_REQ_DECIDE: begin
                    r_aimed <= w_lead_ok ? r_next : '0;
                end
                vfp_pkg::S_PRS_PER: begin
                    r_last <= r_now;
                    if (r_ev != '0) begin
                        r_period <= {{(PW-CW){1'b0}}, r_ev};
                    end
                end
                vfp_pkg::S_PRS_DIV: begin
                    if (w_div_rsp.done) begin
                        r_period <= w_div_rsp.quotient[PW-1:0];
                    end
                end
                vfp_pkg::S_PRS_WIDEN: begin
                    r_margin <= (w_min_wc > {{(PW-CW){1'b0}}, {CW{1'b1}}})
                                ? {CW{1'b1}} : w_min_wc[CW-1:0];
                    r_hit    <= '0;
                    r_aimed  <= '0;
                end
                vfp_pkg::S_PRS_HIT: begin
                    if (w_hit_n >= r_hits) begin
                        r_margin <= (w_cand > r_min_margin) ? w_cand : r_min_margin;
                        r_hit    <= '0;
                    end else begin
                        r_hit <= w_hit_n;
                    end
                    r_aimed <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Work registers of the request in flight.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vfp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_now       <= w_in.time_ns;
                    r_ev        <= w_in.event_period_ns;
                    r_start_out <= '0;
                    r_action    <= (w_in.mode == vfp_pkg::MODE_PRESENT)
                                   ? vfp_pkg::ACT_PRESENT : vfp_pkg::ACT_RENDER;
                end
            end
            vfp_pkg::S_REQ_DIFF: begin
                r_tmp <= {1'b0, r_now} - {1'b0, r_last};
            end
            vfp_pkg::S_REQ_ABS: begin
                r_neg <= r_tmp[XW-1];
            end
            vfp_pkg::S_REQ_DIV: begin
                if (w_div_rsp.done) begin
                    r_tmp <= w_rem_s;
                end
            end
            // The next vblank is now - remainder + period, which equals
            // last + (quotient + 1) * period without a multiplier.
            vfp_pkg::S_REQ_NEXT1: begin
                r_tmp <= {1'b0, r_now} - r_tmp;
            end
            vfp_pkg::S_REQ_NEXT2: begin
                r_next <= r_tmp + {{(XW-PW){1'b0}}, r_period};
            end
            vfp_pkg::S_REQ_START: begin
                r_start <= r_next - {{(XW-CW){1'b0}}, r_margin};
            end
            vfp_pkg::S_REQ_LEAD: begin
                r_tmp <= r_start - {1'b0, r_now};
            end
            vfp_pkg::S_REQ_DECIDE: begin
                if (w_lead_ok) begin
                    r_action    <= vfp_pkg::ACT_ARMED;
                    r_start_out <= r_start[TW-1:0];
                end
            end
            vfp_pkg::S_PRS_CHK: begin
                r_tmp <= r_aimed + {{(XW-PW){1'b0}}, w_cap};
            end
            vfp_pkg::S_PRS_CMP: begin
                r_wide <= {3'b000, r_margin} + {1'b0, r_step, 2'b00};
            end
            vfp_pkg::S_FINISH: begin
                if (w_out_load) begin
                    r_out.action    <= r_action;
                    r_out.start_ns  <= r_start_out;
                    r_out.margin_ns <= r_margin;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/vfp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both request types.
`default_nettype none

module vfp_divider (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  vfp_pkg::t_div_req  i_req,
    output vfp_pkg::t_div_rsp  o_rsp
);

    localparam int W  = vfp_pkg::DIV_W;
    localparam int RW = vfp_pkg::PERIOD_W;
    localparam logic [vfp_pkg::DIV_CNT_W-1:0] CNT_LAST = vfp_pkg::DIV_CNT_W'(W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [vfp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [W-1:0]                  r_quo;
    logic [RW-1:0]                 r_rem;
    logic [RW-1:0]                 r_den;

    logic [RW:0]   w_shift;
    logic [RW:0]   w_trial;
    logic          w_bit;
    logic [RW-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_trial = w_shift - {1'b0, r_den};
        w_bit   = ~w_trial[RW];
        n_rem   = w_bit ? w_trial[RW-1:0] : w_shift[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + vfp_pkg::DIV_CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire
